[rtl/mbmt_pkg.sv]
// Shared types and codes for the binding match table.
package mbmt_pkg;

  localparam int MAX_BINDINGS_DEF = 32;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_MATCH_TRIG = 3'd3,
    OP_MATCH_MIDI = 3'd4,
    OP_MATCH_KEY  = 3'd5
  } op_t;

  localparam logic [2:0] TRIG_NONE = 3'd0;
  localparam logic [2:0] TRIG_NOTE = 3'd1;
  localparam logic [2:0] TRIG_CC   = 3'd2;
  localparam logic [2:0] TRIG_PROG = 3'd3;
  localparam logic [2:0] TRIG_KEY  = 3'd4;

  localparam logic [2:0] ACT_NONE  = 3'd0;

  localparam logic [3:0] MIDI_NOTE_ON = 4'h9;
  localparam logic [3:0] MIDI_CC      = 4'hB;
  localparam logic [3:0] MIDI_PROG    = 4'hC;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [2:0]  ttype;
    logic [4:0]  tchan;
    logic [15:0] tnum;
    logic [2:0]  atype;
    logic [7:0]  aidx;
  } entry_t;

  // Match token handed from cell to cell.
  typedef struct packed {
    logic       active;
    logic       found;
    logic [2:0] kind;
    logic [7:0] slot;
  } token_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic        do_add;
    logic        do_remove;
    entry_t      new_entry;
    logic [2:0]  q_type;
    logic [4:0]  q_chan;
    logic [15:0] q_num;
  } cell_ctl_t;

endpackage

[rtl/mbmt_if.sv]
// Handshake channels for requests and results of the binding match table.
interface mbmt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [2:0]  trig_type;
  logic [4:0]  trig_channel;
  logic [15:0] trig_number;
  logic [2:0]  act_type;
  logic [7:0]  act_index;
  logic [7:0]  entry_index;
  logic [7:0]  midi_status;
  logic [6:0]  midi_data1;
  logic [6:0]  midi_data2;
  logic [15:0] key_code;

  modport source (
    output valid, op, trig_type, trig_channel, trig_number, act_type, act_index,
           entry_index, midi_status, midi_data1, midi_data2, key_code,
    input  ready
  );
  modport sink (
    input  valid, op, trig_type, trig_channel, trig_number, act_type, act_index,
           entry_index, midi_status, midi_data1, midi_data2, key_code,
    output ready
  );
endinterface

interface mbmt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action_kind;
  logic [7:0] action_slot;
  logic [5:0] entry_count;
  logic       add_dropped;

  modport source (
    output valid, action_kind, action_slot, entry_count, add_dropped,
    input  ready
  );
  modport sink (
    input  valid, action_kind, action_slot, entry_count, add_dropped,
    output ready
  );
endinterface

[rtl/mbmt_cell.sv]
// One table position: holds a binding, shifts on remove, checks the passing match token.
module mbmt_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CW         = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  mbmt_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  logic [CW-1:0]      rm_start,
  input  mbmt_pkg::entry_t   nb_entry,
  output mbmt_pkg::entry_t   entry,
  input  mbmt_pkg::token_t   tok_in,
  output mbmt_pkg::token_t   tok_out
);
  import mbmt_pkg::*;

  localparam logic [CW-1:0] MY_POS = CW'(CELL_INDEX);

  logic in_use;
  logic chan_ok;
  logic hit;

  assign in_use  = MY_POS < count;
  assign chan_ok = (entry.tchan == 5'd0) || (ctl.q_chan == 5'd0) ||
                   (entry.tchan == ctl.q_chan);
  assign hit = tok_in.active && !tok_in.found && in_use &&
               (ctl.q_type != TRIG_NONE) && (entry.ttype == ctl.q_type) &&
               (entry.tnum == ctl.q_num) && chan_ok;

  // Add lands at the first free slot; remove pulls the neighbor down.
  always_ff @(posedge clk) begin
    if (ctl.do_add && (count == MY_POS)) begin
      entry <= ctl.new_entry;
    end else if (ctl.do_remove && (MY_POS >= rm_start)) begin
      entry <= nb_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
      tok_out.found  <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
      tok_out.found  <= tok_in.found | hit;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.kind <= hit ? entry.atype : tok_in.kind;
    tok_out.slot <= hit ? entry.aidx  : tok_in.slot;
  end

endmodule

[rtl/midi_binding_match_table.sv]
// Top level of the binding match table: sequencer, result register and the row of cells.
//
// Usage:
//   req carries one operation per item (add, remove, clear, or one of three
//   match forms); rsp returns exactly one result item per request with the
//   matched action, the binding count after the operation and the add-full flag.
//   Both channels move an item when valid and ready are high at a clock edge.
// Timing:
//   One request is in work at a time; req.ready is high while the sequencer idles.
//   Add, remove and clear update the table at the accept edge; the sequencer then
//   holds their result. A match registers a launch flag and sends a token down the row of
//   MAX_BINDINGS cells, one cell per cycle; the sequencer holds the result once the
//   token leaves the last cell. A held result moves into the output register when it
//   is free, and req.ready returns as it does.
// Reset:
//   rst (synchronous) empties the table (count 0) and drops any pending result.
//   Table contents are not cleared; only positions below the count are read.
// Stall:
//   A result waits in the output register while rsp.ready is low; a finished
//   next result waits in the sequencer until the register frees up.
module midi_binding_match_table #(
  parameter int MAX_BINDINGS = mbmt_pkg::MAX_BINDINGS_DEF
) (
  input logic       clk,
  input logic       rst,
  mbmt_req_if.sink  req,
  mbmt_rsp_if.source rsp
);
  import mbmt_pkg::*;

  localparam int CW = $clog2(MAX_BINDINGS + 1);
  localparam int IW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BINDINGS);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic          req_fire;
  logic          is_full;
  logic          rm_ok;
  logic          is_match;
  logic          rsp_load;

  logic [3:0]    midi_hi;
  logic [4:0]    midi_chan;
  logic [2:0]    midi_type;
  logic [2:0]    qt_next;
  logic [4:0]    qc_next;
  logic [15:0]   qn_next;

  logic [2:0]    q_type;
  logic [4:0]    q_chan;
  logic [15:0]   q_num;
  logic          launch;

  logic [2:0]    pend_kind;
  logic [7:0]    pend_slot;
  logic          pend_dropped;

  logic          rsp_valid;
  logic [2:0]    rsp_kind;
  logic [7:0]    rsp_slot;
  logic [5:0]    rsp_count;
  logic          rsp_dropped;

  cell_ctl_t     ctl;
  logic [CW-1:0] rm_start;
  entry_t        ent [MAX_BINDINGS];
  token_t        tok [MAX_BINDINGS+1];
  logic [MAX_BINDINGS-1:0] tok_active;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign is_full   = (count == FULL_COUNT);
  assign rm_ok     = IW'(req.entry_index) < IW'(count);
  assign is_match  = (req.op == OP_MATCH_TRIG) || (req.op == OP_MATCH_MIDI) ||
                     (req.op == OP_MATCH_KEY);

  // MIDI message classification
  assign midi_hi   = req.midi_status[7:4];
  assign midi_chan = (req.midi_status >= 8'h80 && req.midi_status <= 8'hEF) ?
                     ({1'b0, req.midi_status[3:0]} + 5'd1) : 5'd0;

  always_comb begin
    case (midi_hi)
      MIDI_NOTE_ON: midi_type = (req.midi_data2 != 7'd0) ? TRIG_NOTE : TRIG_NONE;
      MIDI_CC:      midi_type = TRIG_CC;
      MIDI_PROG:    midi_type = TRIG_PROG;
      default:      midi_type = TRIG_NONE;
    endcase
  end

  always_comb begin
    case (req.op)
      OP_MATCH_TRIG: begin
        qt_next = req.trig_type;
        qc_next = req.trig_channel;
        qn_next = req.trig_number;
      end
      OP_MATCH_MIDI: begin
        qt_next = midi_type;
        qc_next = midi_chan;
        qn_next = {9'd0, req.midi_data1};
      end
      OP_MATCH_KEY: begin
        qt_next = TRIG_KEY;
        qc_next = 5'd0;
        qn_next = req.key_code;
      end
      default: begin
        qt_next = TRIG_NONE;
        qc_next = 5'd0;
        qn_next = 16'd0;
      end
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    ctl.do_add          = req_fire && (req.op == OP_ADD) && !is_full;
    ctl.do_remove       = req_fire && (req.op == OP_REMOVE) && rm_ok;
    ctl.new_entry.ttype = req.trig_type;
    ctl.new_entry.tchan = req.trig_channel;
    ctl.new_entry.tnum  = req.trig_number;
    ctl.new_entry.atype = req.act_type;
    ctl.new_entry.aidx  = req.act_index;
    ctl.q_type          = q_type;
    ctl.q_chan          = q_chan;
    ctl.q_num           = q_num;
  end

  // Only used when the remove is in range, so it fits in the count width.
  assign rm_start = CW'(req.entry_index);

  assign tok[0] = '{active: launch, found: 1'b0, kind: ACT_NONE, slot: 8'd0};

  for (genvar i = 0; i < MAX_BINDINGS; i++) begin : g_cell
    entry_t nb;
    if (i == MAX_BINDINGS - 1) begin : g_last
      assign nb = ent[i];
    end else begin : g_mid
      assign nb = ent[i+1];
    end

    mbmt_cell #(
      .CELL_INDEX (i),
      .CW         (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .count    (count),
      .rm_start (rm_start),
      .nb_entry (nb),
      .entry    (ent[i]),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );

    assign tok_active[i] = tok[i+1].active;
  end

  assign rsp_load = (state == ST_HOLD) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = is_match ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (tok[MAX_BINDINGS].active) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      launch <= 1'b0;
    end else begin
      launch <= req_fire && is_match;
      if (ctl.do_add) begin
        count <= count + CW'(1);
      end else if (ctl.do_remove) begin
        count <= count - CW'(1);
      end else if (req_fire && (req.op == OP_CLEAR)) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      q_type       <= qt_next;
      q_chan       <= qc_next;
      q_num        <= qn_next;
      pend_kind    <= ACT_NONE;
      pend_slot    <= 8'd0;
      pend_dropped <= (req.op == OP_ADD) && is_full;
    end else if ((state == ST_SCAN) && tok[MAX_BINDINGS].active) begin
      pend_kind    <= tok[MAX_BINDINGS].kind;
      pend_slot    <= tok[MAX_BINDINGS].slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_kind    <= pend_kind;
      rsp_slot    <= pend_slot;
      rsp_count   <= 6'(count);
      rsp_dropped <= pend_dropped;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.action_kind = rsp_kind;
  assign rsp.action_slot = rsp_slot;
  assign rsp.entry_count = rsp_count;
  assign rsp.add_dropped = rsp_dropped;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("binding count above table size");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_active) <= 1)
    else $error("more than one match token in the row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_BINDINGS].active |-> (state == ST_SCAN))
    else $error("match token finished outside a scan");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    ctl.do_add |=> (count == $past(count) + CW'(1)))
    else $error("add did not grow the table");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.op == OP_CLEAR)) |=> (count == '0))
    else $error("clear left bindings");
`endif

endmodule
